>>> rtl/core/bpsu_pkg.sv
// Shared types and constants for the buffer pattern search unit.
`default_nettype none

package bpsu_pkg;

    localparam int BUF_DEPTH_DEFAULT = 4096;
    localparam int PAT_MAX_DEFAULT   = 16;

    localparam int CMD_W        = 2;
    localparam int ADDR_W       = 12;
    localparam int BYTE_W       = 8;
    localparam int OFFSET_W     = 13;
    localparam int PAT_LEN_W    = 5;
    localparam int PAT_BYTES    = 16;
    localparam int PAT_IDX_W    = 4;
    localparam int CFG_INDEX_W  = 4;
    localparam int CFG_DATA_W   = 64;
    localparam int BUF_LEN_W    = 13;

    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FWD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_BWD   = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LEN = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LO  = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HI  = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BUFFER_LEN  = 4'd3;

    typedef enum logic [2:0] {
        OP_WRITE,
        OP_MISS,
        OP_HIT,
        OP_FWD,
        OP_BWD
    } op_t;

    typedef struct packed {
        logic [PAT_LEN_W-1:0]            plen;
        logic [PAT_BYTES*BYTE_W-1:0]     pattern;
    } cfg_t;

endpackage

`default_nettype wire

>>> rtl/core/buffer_pattern_search_unit.sv
// Top level of the buffer pattern search unit: intake, queue and execution stages.
// Writes sustain one beat per cycle while the execution stage is idle; a trivial search
// result passes through the queue and the result register. A scan tests one candidate at a
// time, moving on at its first mismatching byte, bounded by the single read port of the byte
// store; intake stalls once the queue fills. Reset clears the configuration registers, the queue
// and the result valid flag; the byte store is not cleared and has no clearing pass.
`default_nettype none

module buffer_pattern_search_unit #(
    parameter int BUF_DEPTH = bpsu_pkg::BUF_DEPTH_DEFAULT,
    parameter int PAT_MAX   = bpsu_pkg::PAT_MAX_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              item_valid,
    output logic                                   item_ready,
    input  wire logic [bpsu_pkg::CMD_W-1:0]        cmd,
    input  wire logic [bpsu_pkg::ADDR_W-1:0]       addr,
    input  wire logic [bpsu_pkg::BYTE_W-1:0]       wdata,
    input  wire logic [bpsu_pkg::OFFSET_W-1:0]     start_offset,
    input  wire logic [bpsu_pkg::OFFSET_W-1:0]     end_offset,
    output logic                                   result_valid,
    input  wire logic                              result_ready,
    output logic                                   found,
    output logic [bpsu_pkg::OFFSET_W-1:0]          position,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [bpsu_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [bpsu_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import bpsu_pkg::*;

    localparam int DW = $clog2(BUF_DEPTH + 1);
    localparam int OW = (DW > OFFSET_W) ? DW : OFFSET_W;

    typedef struct packed {
        op_t               op;
        logic [OW-1:0]     pos;
        logic [OW-1:0]     lim;
        logic [BYTE_W-1:0] wdata;
    } entry_t;

    cfg_t   cfg;
    logic   push_valid;
    logic   push_ready;
    entry_t push_entry;
    logic   q_valid;
    logic   q_pop;
    entry_t q_entry;

    bpsu_front #(
        .BUF_DEPTH (BUF_DEPTH),
        .PAT_MAX   (PAT_MAX),
        .entry_t   (entry_t)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .cmd          (cmd),
        .addr         (addr),
        .wdata        (wdata),
        .start_offset (start_offset),
        .end_offset   (end_offset),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_entry   (push_entry)
    );

    bpsu_queue #(
        .entry_t (entry_t)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (q_valid),
        .pop_ready  (q_pop),
        .pop_entry  (q_entry)
    );

    bpsu_back #(
        .BUF_DEPTH (BUF_DEPTH),
        .entry_t   (entry_t)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_entry      (q_entry),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .found        (found),
        .position     (position)
    );

endmodule

`default_nettype wire

>>> rtl/core/bpsu_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module bpsu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/core/bpsu_front.sv
// Intake stage: configuration registers, command decode and search setup.
`default_nettype none

module bpsu_front #(
    parameter int  BUF_DEPTH = 4096,
    parameter int  PAT_MAX   = 16,
    parameter type entry_t   = logic
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              item_valid,
    output logic                                   item_ready,
    input  wire logic [bpsu_pkg::CMD_W-1:0]        cmd,
    input  wire logic [bpsu_pkg::ADDR_W-1:0]       addr,
    input  wire logic [bpsu_pkg::BYTE_W-1:0]       wdata,
    input  wire logic [bpsu_pkg::OFFSET_W-1:0]     start_offset,
    input  wire logic [bpsu_pkg::OFFSET_W-1:0]     end_offset,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [bpsu_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [bpsu_pkg::CFG_DATA_W-1:0]   cfg_data,
    output bpsu_pkg::cfg_t                         cfg,
    output logic                                   push_valid,
    input  wire logic                              push_ready,
    output entry_t                                 push_entry
);

    import bpsu_pkg::*;

    localparam int DW = $clog2(BUF_DEPTH + 1);
    localparam int OW = (DW > OFFSET_W) ? DW : OFFSET_W;
    localparam logic [OW-1:0] DEPTH_O = OW'(BUF_DEPTH);

    logic [PAT_LEN_W-1:0]  pattern_len_reg;
    logic [CFG_DATA_W-1:0] pattern_lo_reg;
    logic [CFG_DATA_W-1:0] pattern_hi_reg;
    logic [BUF_LEN_W-1:0]  buffer_len_reg;

    logic [PAT_LEN_W-1:0]  plen;
    logic [OW-1:0]         plen_o;
    logic [OW-1:0]         start_w;
    logic [OW-1:0]         end_w;
    logic [OW-1:0]         blen_w;
    logic [OW-1:0]         start_c;
    logic [OW-1:0]         end_c;
    logic [OW-1:0]         blen_c;
    logic [OW-1:0]         fwd_end;
    logic [OW-1:0]         fwd_last;
    logic [OW-1:0]         blen_m1;
    logic [OW-1:0]         bwd_s;
    logic                  keep;
    entry_t                entry;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_len_reg <= '0;
            pattern_lo_reg  <= '0;
            pattern_hi_reg  <= '0;
            buffer_len_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_PATTERN_LEN: pattern_len_reg <= cfg_data[PAT_LEN_W-1:0];
                REG_PATTERN_LO:  pattern_lo_reg  <= cfg_data;
                REG_PATTERN_HI:  pattern_hi_reg  <= cfg_data;
                REG_BUFFER_LEN:  buffer_len_reg  <= cfg_data[BUF_LEN_W-1:0];
                default:         ;
            endcase
        end
    end

    assign plen = (pattern_len_reg > PAT_LEN_W'(PAT_MAX)) ? PAT_LEN_W'(PAT_MAX)
                                                          : pattern_len_reg;
    assign plen_o  = OW'(plen);
    assign start_w = OW'(start_offset);
    assign end_w   = OW'(end_offset);
    assign blen_w  = OW'(buffer_len_reg);

    assign start_c  = (start_w > DEPTH_O) ? DEPTH_O : start_w;
    assign end_c    = (end_w > DEPTH_O) ? DEPTH_O : end_w;
    assign blen_c   = (blen_w > DEPTH_O) ? DEPTH_O : blen_w;
    assign fwd_end  = (end_c < blen_c) ? end_c : blen_c;
    assign fwd_last = fwd_end - plen_o;
    assign blen_m1  = blen_c - OW'(1);
    assign bwd_s    = (start_c < blen_m1) ? start_c : blen_m1;

    always_comb
    begin
        keep        = 1'b0;
        entry       = '0;
        entry.op    = OP_MISS;
        entry.wdata = wdata;
        case (cmd)
            CMD_WRITE:
            begin
                keep      = int'(addr) < BUF_DEPTH;
                entry.op  = OP_WRITE;
                entry.pos = OW'(addr);
            end
            CMD_FWD:
            begin
                keep = 1'b1;
                if (blen_c == '0 || plen_o > fwd_end || start_c > fwd_last)
                begin
                    entry.op = OP_MISS;
                end
                else if (plen == '0)
                begin
                    entry.op  = OP_HIT;
                    entry.pos = start_c;
                end
                else
                begin
                    entry.op  = OP_FWD;
                    entry.pos = start_c;
                    entry.lim = fwd_last;
                end
            end
            CMD_BWD:
            begin
                keep = 1'b1;
                if (blen_c == '0)
                begin
                    entry.op = OP_MISS;
                end
                else if (plen == '0)
                begin
                    entry.op  = OP_HIT;
                    entry.pos = bwd_s;
                end
                else if (plen_o > bwd_s)
                begin
                    entry.op = OP_MISS;
                end
                else
                begin
                    entry.op  = OP_BWD;
                    entry.pos = bwd_s - plen_o;
                end
            end
            default: keep = 1'b0;
        endcase
    end

    assign item_ready  = push_ready;
    assign push_valid  = item_valid && keep;
    assign push_entry  = entry;
    assign cfg.plen    = plen;
    assign cfg.pattern = {pattern_hi_reg, pattern_lo_reg};

endmodule

`default_nettype wire

>>> rtl/core/bpsu_queue.sv
// Two-entry queue between intake and execution.
`default_nettype none

module bpsu_queue #(
    parameter type entry_t = logic
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic      push_ready,
    input  entry_t    push_entry,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output entry_t    pop_entry
);

    entry_t     slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = count_reg != 2'd2;
    assign pop_valid  = count_reg != 2'd0;
    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/bpsu_back.sv
// Execution stage: byte store, candidate scan and result register.
`default_nettype none

module bpsu_back #(
    parameter int  BUF_DEPTH = 4096,
    parameter type entry_t   = logic
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  bpsu_pkg::cfg_t                     cfg,
    input  wire logic                          q_valid,
    output logic                               q_pop,
    input  entry_t                             q_entry,
    output logic                               result_valid,
    input  wire logic                          result_ready,
    output logic                               found,
    output logic [bpsu_pkg::OFFSET_W-1:0]      position
);

    import bpsu_pkg::*;

    localparam int AW = $clog2(BUF_DEPTH);
    localparam int DW = $clog2(BUF_DEPTH + 1);
    localparam int OW = (DW > OFFSET_W) ? DW : OFFSET_W;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t                state_reg,     state_next;
    logic                  fwd_reg,       fwd_next;
    logic [OW-1:0]         cand_reg,      cand_next;
    logic [OW-1:0]         lim_reg,       lim_next;
    logic [PAT_LEN_W-1:0]  ii_reg,        ii_next;
    logic [PAT_IDX_W-1:0]  ci_reg,        ci_next;
    logic                  cvalid_reg,    cvalid_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  found_reg,     found_next;
    logic [OFFSET_W-1:0]   position_reg,  position_next;

    logic                  slot_free;
    logic                  ram_we;
    logic [OW-1:0]         rd_sum;
    logic [BYTE_W-1:0]     rdata;
    logic [BYTE_W-1:0]     pat_byte;
    logic                  match;
    logic                  cand_end;

    bpsu_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BUF_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (q_entry.pos[AW-1:0]),
        .wdata (q_entry.wdata),
        .raddr (rd_sum[AW-1:0]),
        .rdata (rdata)
    );

    assign slot_free = !out_valid_reg || result_ready;
    assign rd_sum    = cand_reg + OW'(ii_reg);
    assign pat_byte  = cfg.pattern[{ci_reg, 3'b000} +: BYTE_W];
    assign match     = rdata == pat_byte;
    assign cand_end  = fwd_reg ? (cand_reg == lim_reg) : (cand_reg == '0);
    assign ram_we    = (state_reg == ST_IDLE) && q_valid && (q_entry.op == OP_WRITE);

    always_comb
    begin
        state_next     = state_reg;
        fwd_next       = fwd_reg;
        cand_next      = cand_reg;
        lim_next       = lim_reg;
        ii_next        = ii_reg;
        ci_next        = ci_reg;
        cvalid_next    = 1'b0;
        out_valid_next = out_valid_reg && !result_ready;
        found_next     = found_reg;
        position_next  = position_reg;
        q_pop          = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_entry.op)
                        OP_WRITE:
                        begin
                            q_pop = 1'b1;
                        end
                        OP_MISS, OP_HIT:
                        begin
                            if (slot_free)
                            begin
                                q_pop          = 1'b1;
                                out_valid_next = 1'b1;
                                found_next     = q_entry.op == OP_HIT;
                                position_next  = (q_entry.op == OP_HIT)
                                               ? q_entry.pos[OFFSET_W-1:0] : '0;
                            end
                        end
                        OP_FWD, OP_BWD:
                        begin
                            if (slot_free)
                            begin
                                q_pop      = 1'b1;
                                fwd_next   = q_entry.op == OP_FWD;
                                cand_next  = q_entry.pos;
                                lim_next   = q_entry.lim;
                                ii_next    = '0;
                                state_next = ST_SCAN;
                            end
                        end
                        default: q_pop = 1'b1;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (cvalid_reg && match && (PAT_LEN_W'(ci_reg) + PAT_LEN_W'(1) == cfg.plen))
                begin
                    out_valid_next = 1'b1;
                    found_next     = 1'b1;
                    position_next  = cand_reg[OFFSET_W-1:0];
                    state_next     = ST_IDLE;
                end
                else if (cvalid_reg && !match)
                begin
                    if (cand_end)
                    begin
                        out_valid_next = 1'b1;
                        found_next     = 1'b0;
                        position_next  = '0;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        cand_next = fwd_reg ? cand_reg + OW'(1) : cand_reg - OW'(1);
                        ii_next   = '0;
                    end
                end
                else if (ii_reg < cfg.plen)
                begin
                    ii_next     = ii_reg + PAT_LEN_W'(1);
                    ci_next     = ii_reg[PAT_IDX_W-1:0];
                    cvalid_next = 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cvalid_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cvalid_reg    <= cvalid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_reg      <= fwd_next;
        cand_reg     <= cand_next;
        lim_reg      <= lim_next;
        ii_reg       <= ii_next;
        ci_reg       <= ci_next;
        found_reg    <= found_next;
        position_reg <= position_next;
    end

    assign result_valid = out_valid_reg;
    assign found        = found_reg;
    assign position     = position_reg;

endmodule

`default_nettype wire

>>> rtl/core/bpsu_checker.sv
// Port-level checks for the buffer pattern search unit, bound to the top level.
`default_nettype none

module bpsu_port_checks (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          result_valid,
    input wire logic                          result_ready,
    input wire logic                          found,
    input wire logic [bpsu_pkg::OFFSET_W-1:0] position
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(found) && $stable(position))
        else $error("result beat changed before it was taken");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !found |-> position == '0)
        else $error("miss beat carries a nonzero position");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !result_valid)
        else $error("result beat shown during reset");

endmodule

bind buffer_pattern_search_unit bpsu_port_checks u_bpsu_port_checks (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .found        (found),
    .position     (position)
);

`default_nettype wire
